[hdl/cac_pkg.sv]
// ----------------------------------------------------------------------------
// cac_pkg
// Types, register codes and reset values shared by the climate controller.
// ----------------------------------------------------------------------------
`default_nettype none

package cac_pkg;

  // Configuration register indexes, in write-port order.
  typedef enum logic [2:0] {
    CFG_ENABLE_FLAGS     = 3'd0,
    CFG_LIGHT_ON_MINUTE  = 3'd1,
    CFG_LIGHT_OFF_MINUTE = 3'd2,
    CFG_FAN_THRESHOLD    = 3'd3,
    CFG_FAN_HYSTERESIS   = 3'd4,
    CFG_ALARM_THRESHOLD  = 3'd5,
    CFG_ALARM_DWELL_MS   = 3'd6
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  // Bit positions inside enable_flags.
  localparam int unsigned EnSchedBit = 0;
  localparam int unsigned EnFanBit   = 1;
  localparam int unsigned EnAlarmBit = 2;

  // Register reset values.
  localparam logic [2:0]  EnableFlagsRst    = 3'd0;
  localparam logic [10:0] LightOnMinuteRst  = 11'd360;
  localparam logic [10:0] LightOffMinuteRst = 11'd1320;
  localparam logic [11:0] FanThresholdRst   = 12'd280;
  localparam logic [9:0]  FanHysteresisRst  = 10'd20;
  localparam logic [9:0]  AlarmThresholdRst = 10'd300;
  localparam logic [31:0] AlarmDwellMsRst   = 32'd0;

  // Register file contents.
  typedef struct packed {
    logic [2:0]  enable_flags;
    logic [10:0] light_on_minute;
    logic [10:0] light_off_minute;
    logic [11:0] fan_threshold;
    logic [9:0]  fan_hysteresis;
    logic [9:0]  alarm_threshold;
    logic [31:0] alarm_dwell_ms;
  } cfg_t;

  // One poll word.
  typedef struct packed {
    logic [31:0] now_ms;
    logic [10:0] minute_of_day;
    logic        clock_valid;
    logic [11:0] inside_temp;
    logic        inside_fault;
    logic [9:0]  moisture_level;
    logic        moisture_calibrated;
    logic        moisture_fault;
  } poll_t;

  // One result word.
  typedef struct packed {
    logic lights_on;
    logic fans_on;
    logic alarm_active;
    logic alarm_new;
    logic lights_scheduled;
    logic fans_paused;
    logic schedule_enabled;
    logic outputs_changed;
  } res_t;

endpackage

`default_nettype wire

[hdl/cac_if.sv]
// ----------------------------------------------------------------------------
// cac_if
// Valid/ready channels for poll words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface cac_poll_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;
  logic [10:0] minute_of_day;
  logic        clock_valid;
  logic signed [11:0] inside_temp;
  logic        inside_fault;
  logic [9:0]  moisture_level;
  logic        moisture_calibrated;
  logic        moisture_fault;

  modport source (
    output valid, now_ms, minute_of_day, clock_valid, inside_temp, inside_fault,
           moisture_level, moisture_calibrated, moisture_fault,
    input  ready
  );
  modport sink (
    input  valid, now_ms, minute_of_day, clock_valid, inside_temp, inside_fault,
           moisture_level, moisture_calibrated, moisture_fault,
    output ready
  );
endinterface

interface cac_res_if;
  logic valid;
  logic ready;
  logic lights_on;
  logic fans_on;
  logic alarm_active;
  logic alarm_new;
  logic lights_scheduled;
  logic fans_paused;
  logic schedule_enabled;
  logic outputs_changed;

  modport source (
    output valid, lights_on, fans_on, alarm_active, alarm_new, lights_scheduled,
           fans_paused, schedule_enabled, outputs_changed,
    input  ready
  );
  modport sink (
    input  valid, lights_on, fans_on, alarm_active, alarm_new, lights_scheduled,
           fans_paused, schedule_enabled, outputs_changed,
    output ready
  );
endinterface

`default_nettype wire

[hdl/cac_cfg_regs.sv]
// ----------------------------------------------------------------------------
// cac_cfg_regs
// Configuration register file with a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module cac_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [cac_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [cac_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output      cac_pkg::cfg_t                 cfg_o
);

  cac_pkg::cfg_t cfg_q, cfg_d;

  // Decode the write and replace the addressed field, truncated to its width.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cac_pkg::cfg_idx_e'(cfg_idx_i))
        cac_pkg::CFG_ENABLE_FLAGS:     cfg_d.enable_flags     = cfg_wdata_i[2:0];
        cac_pkg::CFG_LIGHT_ON_MINUTE:  cfg_d.light_on_minute  = cfg_wdata_i[10:0];
        cac_pkg::CFG_LIGHT_OFF_MINUTE: cfg_d.light_off_minute = cfg_wdata_i[10:0];
        cac_pkg::CFG_FAN_THRESHOLD:    cfg_d.fan_threshold    = cfg_wdata_i[11:0];
        cac_pkg::CFG_FAN_HYSTERESIS:   cfg_d.fan_hysteresis   = cfg_wdata_i[9:0];
        cac_pkg::CFG_ALARM_THRESHOLD:  cfg_d.alarm_threshold  = cfg_wdata_i[9:0];
        cac_pkg::CFG_ALARM_DWELL_MS:   cfg_d.alarm_dwell_ms   = cfg_wdata_i[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable_flags     <= cac_pkg::EnableFlagsRst;
      cfg_q.light_on_minute  <= cac_pkg::LightOnMinuteRst;
      cfg_q.light_off_minute <= cac_pkg::LightOffMinuteRst;
      cfg_q.fan_threshold    <= cac_pkg::FanThresholdRst;
      cfg_q.fan_hysteresis   <= cac_pkg::FanHysteresisRst;
      cfg_q.alarm_threshold  <= cac_pkg::AlarmThresholdRst;
      cfg_q.alarm_dwell_ms   <= cac_pkg::AlarmDwellMsRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[hdl/cac_decide.sv]
// ----------------------------------------------------------------------------
// cac_decide
// Relay and alarm decision logic with the controller state registers.
// ----------------------------------------------------------------------------
`default_nettype none

module cac_decide (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire cac_pkg::cfg_t  cfg_i,
  input  wire cac_pkg::poll_t poll_i,
  input  wire logic           step_i,
  output      cac_pkg::res_t  res_o
);

  logic        lights_q, lights_d;
  logic        fans_q, fans_d;
  logic        alarm_q, alarm_d;
  logic        below_valid_q, below_valid_d;
  logic [31:0] below_since_q, below_since_d;

  logic        sched_en, fan_en, alarm_en;
  logic        sched, paused;
  logic        lights_want, fans_want, alarm_want;
  logic        lights_chg, fans_chg, alarm_chg;
  logic signed [12:0] off_level;
  logic signed [12:0] temp_ext;
  logic signed [12:0] thr_ext;
  logic [31:0] since_eff;
  logic [31:0] elapsed;
  logic        qual, below;

  assign sched_en = cfg_i.enable_flags[cac_pkg::EnSchedBit];
  assign fan_en   = cfg_i.enable_flags[cac_pkg::EnFanBit];
  assign alarm_en = cfg_i.enable_flags[cac_pkg::EnAlarmBit];
  assign sched    = sched_en & poll_i.clock_valid;
  assign paused   = fan_en & poll_i.inside_fault;

  // Light window; an on minute above the off minute wraps past midnight.
  always_comb begin
    if (cfg_i.light_on_minute <= cfg_i.light_off_minute) begin
      lights_want = (poll_i.minute_of_day >= cfg_i.light_on_minute) &&
                    (poll_i.minute_of_day <  cfg_i.light_off_minute);
    end else begin
      lights_want = (poll_i.minute_of_day >= cfg_i.light_on_minute) ||
                    (poll_i.minute_of_day <  cfg_i.light_off_minute);
    end
  end
  assign lights_chg = sched && (lights_want != lights_q);
  assign lights_d   = sched ? lights_want : lights_q;

  // Fan hysteresis at 13 bits so the off level cannot overflow.
  assign temp_ext  = 13'(signed'(poll_i.inside_temp));
  assign thr_ext   = 13'(signed'(cfg_i.fan_threshold));
  assign off_level = thr_ext - signed'({3'b000, cfg_i.fan_hysteresis});
  assign fans_want = (temp_ext >= thr_ext) || (fans_q && (temp_ext > off_level));
  assign fans_chg  = fan_en && !poll_i.inside_fault && (fans_want != fans_q);
  assign fans_d    = (fan_en && !poll_i.inside_fault) ? fans_want : fans_q;

  // Moisture dwell timer; the start time is taken on the first low poll.
  assign qual      = alarm_en && poll_i.moisture_calibrated && !poll_i.moisture_fault;
  assign below     = poll_i.moisture_level < cfg_i.alarm_threshold;
  assign since_eff = below_valid_q ? below_since_q : poll_i.now_ms;
  assign elapsed   = poll_i.now_ms - since_eff;

  always_comb begin
    alarm_want    = 1'b0;
    below_valid_d = 1'b0;
    below_since_d = below_since_q;
    if (qual && below) begin
      below_valid_d = 1'b1;
      below_since_d = since_eff;
      alarm_want    = elapsed >= cfg_i.alarm_dwell_ms;
    end
  end
  assign alarm_chg = alarm_en && (alarm_want != alarm_q);
  assign alarm_d   = alarm_en ? alarm_want : alarm_q;

  // State advances once per poll that moves into the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lights_q      <= 1'b0;
      fans_q        <= 1'b0;
      alarm_q       <= 1'b0;
      below_valid_q <= 1'b0;
    end else if (step_i) begin
      lights_q      <= lights_d;
      fans_q        <= fans_d;
      alarm_q       <= alarm_d;
      below_valid_q <= below_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      below_since_q <= below_since_d;
    end
  end

  // Result word for this poll.
  always_comb begin
    res_o.lights_on        = lights_d;
    res_o.fans_on          = fans_d;
    res_o.alarm_active     = alarm_d;
    res_o.alarm_new        = alarm_chg && alarm_want;
    res_o.lights_scheduled = sched;
    res_o.fans_paused      = paused;
    res_o.schedule_enabled = sched_en;
    res_o.outputs_changed  = lights_chg || fans_chg || alarm_chg;
  end

endmodule

`default_nettype wire

[hdl/climate_automation_controller_core.sv]
// ----------------------------------------------------------------------------
// climate_automation_controller_core
// Light schedule, fan hysteresis and moisture alarm control, one poll a word.
// ----------------------------------------------------------------------------
// The core takes one poll word per clock while results are being taken and
// returns one result word for each, in order. A poll is captured in an input
// register, decided by the compare logic and written to the result register
// once that is empty or being read; the sustained rate is one word per cycle
// while the receiver keeps result ready high. The input and result registers
// together give two words of buffering; poll ready follows result ready
// combinationally when both are full. Configuration writes take effect on
// the next cycle and are meant to happen while no poll is in flight.
`default_nettype none

module climate_automation_controller_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [cac_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [cac_pkg::CfgDataW-1:0] cfg_wdata_i,
  cac_poll_if.sink                          poll_i,
  cac_res_if.source                         result_o
);

  cac_pkg::cfg_t  cfg;
  cac_pkg::poll_t poll_in;
  cac_pkg::poll_t poll_q;
  cac_pkg::res_t  res;
  cac_pkg::res_t  res_q;
  logic           in_valid_q, in_valid_d;
  logic           out_valid_q, out_valid_d;
  logic           accept, adv;

  cac_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Pack the channel fields into a poll word.
  always_comb begin
    poll_in.now_ms              = poll_i.now_ms;
    poll_in.minute_of_day       = poll_i.minute_of_day;
    poll_in.clock_valid         = poll_i.clock_valid;
    poll_in.inside_temp         = poll_i.inside_temp;
    poll_in.inside_fault        = poll_i.inside_fault;
    poll_in.moisture_level      = poll_i.moisture_level;
    poll_in.moisture_calibrated = poll_i.moisture_calibrated;
    poll_in.moisture_fault      = poll_i.moisture_fault;
  end

  // Pipeline handshake: a word moves on when the next stage is free.
  assign adv          = in_valid_q && (!out_valid_q || result_o.ready);
  assign poll_i.ready = !in_valid_q || adv;
  assign accept       = poll_i.valid && poll_i.ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (adv) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Input and result payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      poll_q <= poll_in;
    end
    if (adv) begin
      res_q <= res;
    end
  end

  cac_decide u_decide (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .poll_i (poll_q),
    .step_i (adv),
    .res_o  (res)
  );

  // Drive the result channel.
  assign result_o.valid            = out_valid_q;
  assign result_o.lights_on        = res_q.lights_on;
  assign result_o.fans_on          = res_q.fans_on;
  assign result_o.alarm_active     = res_q.alarm_active;
  assign result_o.alarm_new        = res_q.alarm_new;
  assign result_o.lights_scheduled = res_q.lights_scheduled;
  assign result_o.fans_paused      = res_q.fans_paused;
  assign result_o.schedule_enabled = res_q.schedule_enabled;
  assign result_o.outputs_changed  = res_q.outputs_changed;

  // An accepted poll sits in the input register on the next cycle.
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_valid_q)
    else $error("accepted poll did not reach the input register");

  // A result appears only after a word moved out of the input register.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(adv))
    else $error("result became valid without a decided poll");

  // A newly fired alarm is always reported as active.
  a_alarm_new_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.alarm_new) |-> result_o.alarm_active)
    else $error("alarm_new without alarm_active");

  // Scheduled lights imply the schedule enable bit.
  a_sched_enabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.lights_scheduled) |-> result_o.schedule_enabled)
    else $error("lights scheduled while schedule disabled");

endmodule

`default_nettype wire

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for climate_automation_controller_core.
// ----------------------------------------------------------------------------
// Poll words are queued by the stimulus process and fed to the core by a
// clocked driver. Each accepted poll is run through a local model of the light
// schedule, the fan hysteresis and the moisture dwell alarm, and the expected
// result word is queued. A clocked monitor compares every result word, field
// by field, against the oldest expected word. The run starts with a directed
// part and then walks through randomized configuration phases. The sender and
// the receiver stall under three idle patterns.

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallLimit = 2000;

  logic                         clk;
  logic                         rst_n;
  logic                         cfg_we;
  logic [cac_pkg::CfgIdxW-1:0]  cfg_idx;
  logic [cac_pkg::CfgDataW-1:0] cfg_wdata;

  cac_poll_if poll_if ();
  cac_res_if  res_if ();

  climate_automation_controller_core i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .poll_i      (poll_if),
    .result_o    (res_if)
  );

  // Result field names, indexed by bit position in res_t.
  string result_field [8] = '{"outputs_changed", "schedule_enabled", "fans_paused",
                              "lights_scheduled", "alarm_new", "alarm_active",
                              "fans_on", "lights_on"};

  cac_pkg::poll_t pending_polls [$];
  cac_pkg::res_t  expected_results [$];
  cac_pkg::poll_t poll_on_bus;

  // Local copy of the register file and the controller state.
  cac_pkg::cfg_t cfg_model;
  logic          lights_q;
  logic          fans_q;
  logic          alarm_q;
  logic          below_valid_q;
  logic [31:0]   below_since_q;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned errors;
  int unsigned polls_accepted;
  int unsigned results_checked;
  int unsigned alarm_firings;
  int unsigned phase_count;
  int unsigned stall_cycles;
  logic [31:0] poll_clock_ms;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Work out the result word of one poll and advance the local state.
  function automatic cac_pkg::res_t predict_result(cac_pkg::poll_t p);
    cac_pkg::res_t r;
    logic          sched_en;
    logic          fan_en;
    logic          alarm_en;
    logic          want;
    logic          alarm;
    int            temp;
    int            thr;
    int            off_level;
    logic [31:0]   elapsed;
    sched_en = cfg_model.enable_flags[cac_pkg::EnSchedBit];
    fan_en   = cfg_model.enable_flags[cac_pkg::EnFanBit];
    alarm_en = cfg_model.enable_flags[cac_pkg::EnAlarmBit];
    r = '0;
    r.lights_scheduled = sched_en && p.clock_valid;
    r.fans_paused      = fan_en && p.inside_fault;
    r.schedule_enabled = sched_en;

    // Light window; an on minute past the off minute wraps over midnight.
    if (r.lights_scheduled) begin
      if (cfg_model.light_on_minute <= cfg_model.light_off_minute) begin
        want = (p.minute_of_day >= cfg_model.light_on_minute) &&
               (p.minute_of_day < cfg_model.light_off_minute);
      end else begin
        want = (p.minute_of_day >= cfg_model.light_on_minute) ||
               (p.minute_of_day < cfg_model.light_off_minute);
      end
      if (want != lights_q) begin
        lights_q = want;
        r.outputs_changed = 1'b1;
      end
    end

    // Fan hysteresis, held while the inside sensor is faulty.
    if (fan_en && !p.inside_fault) begin
      temp      = $signed(p.inside_temp);
      thr       = $signed(cfg_model.fan_threshold);
      off_level = thr - int'(cfg_model.fan_hysteresis);
      want      = (temp >= thr) || (fans_q && temp > off_level);
      if (want != fans_q) begin
        fans_q = want;
        r.outputs_changed = 1'b1;
      end
    end

    // Moisture dwell timer and alarm.
    alarm = 1'b0;
    if (alarm_en && p.moisture_calibrated && !p.moisture_fault &&
        p.moisture_level < cfg_model.alarm_threshold) begin
      if (!below_valid_q) begin
        below_valid_q = 1'b1;
        below_since_q = p.now_ms;
      end
      elapsed = p.now_ms - below_since_q;
      alarm   = elapsed >= cfg_model.alarm_dwell_ms;
    end else begin
      below_valid_q = 1'b0;
      below_since_q = '0;
    end
    if (alarm_en && alarm != alarm_q) begin
      alarm_q = alarm;
      r.alarm_new = alarm;
      r.outputs_changed = 1'b1;
    end

    r.lights_on    = lights_q;
    r.fans_on      = fans_q;
    r.alarm_active = alarm_q;
    return r;
  endfunction

  function automatic cac_pkg::poll_t make_poll(logic [31:0] now, int minute, bit clk_ok,
                                               int temp, bit tfault, int moist, bit cal,
                                               bit mfault);
    cac_pkg::poll_t p;
    p.now_ms              = now;
    p.minute_of_day       = 11'(minute);
    p.clock_valid         = clk_ok;
    p.inside_temp         = 12'(temp);
    p.inside_fault        = tfault;
    p.moisture_level      = 10'(moist);
    p.moisture_calibrated = cal;
    p.moisture_fault      = mfault;
    return p;
  endfunction

  // Pick the bounds now and then so that the extremes are reached.
  function automatic int pick_range(int lo, int hi);
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 15) return lo;
    if (sel < 30) return hi;
    return lo + int'($urandom_range(hi - lo));
  endfunction

  // Write one register while no poll is in flight.
  task automatic write_cfg(cac_pkg::cfg_idx_e idx, logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    case (idx)
      cac_pkg::CFG_ENABLE_FLAGS:     cfg_model.enable_flags     = val[2:0];
      cac_pkg::CFG_LIGHT_ON_MINUTE:  cfg_model.light_on_minute  = val[10:0];
      cac_pkg::CFG_LIGHT_OFF_MINUTE: cfg_model.light_off_minute = val[10:0];
      cac_pkg::CFG_FAN_THRESHOLD:    cfg_model.fan_threshold    = val[11:0];
      cac_pkg::CFG_FAN_HYSTERESIS:   cfg_model.fan_hysteresis   = val[9:0];
      cac_pkg::CFG_ALARM_THRESHOLD:  cfg_model.alarm_threshold  = val[9:0];
      cac_pkg::CFG_ALARM_DWELL_MS:   cfg_model.alarm_dwell_ms   = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every queued poll has produced its result word.
  task automatic drain();
    do @(negedge clk);
    while (pending_polls.size() != 0 || poll_if.valid || expected_results.size() != 0);
    repeat (3) @(negedge clk);
    phase_count++;
  endtask

  task automatic randomize_config();
    logic [31:0] dwell;
    case ($urandom_range(4))
      0:       dwell = '0;
      1:       dwell = 32'hFFFF_FFFF;
      default: dwell = $urandom_range(0, 3000);
    endcase
    write_cfg(cac_pkg::CFG_ENABLE_FLAGS,
              ($urandom_range(1) != 0) ? 32'd7 : $urandom_range(0, 7));
    write_cfg(cac_pkg::CFG_LIGHT_ON_MINUTE, 32'(pick_range(0, 1439)));
    if ($urandom_range(9) == 0) begin
      write_cfg(cac_pkg::CFG_LIGHT_OFF_MINUTE, 32'(cfg_model.light_on_minute));
    end else begin
      write_cfg(cac_pkg::CFG_LIGHT_OFF_MINUTE, 32'(pick_range(0, 1439)));
    end
    write_cfg(cac_pkg::CFG_FAN_THRESHOLD, 32'(pick_range(-400, 1250)));
    write_cfg(cac_pkg::CFG_FAN_HYSTERESIS, 32'(pick_range(0, 1000)));
    write_cfg(cac_pkg::CFG_ALARM_THRESHOLD, 32'(pick_range(0, 1000)));
    write_cfg(cac_pkg::CFG_ALARM_DWELL_MS, dwell);
    @(negedge clk);
  endtask

  // Polls that mostly form plausible sequences: time moving forward, temperature
  // near the fan threshold, and dry stretches below the alarm level.
  task automatic fill_random(int n);
    int thr;
    int span;
    int temp;
    int minute;
    int moist;
    int alarm_lvl;
    bit dry;
    thr       = $signed(cfg_model.fan_threshold);
    span      = int'(cfg_model.fan_hysteresis) + 30;
    alarm_lvl = int'(cfg_model.alarm_threshold);
    dry       = $urandom_range(1);
    if ($urandom_range(2) == 0) poll_clock_ms = 32'hFFFF_F000 + $urandom_range(4000);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(19) == 0) begin
        poll_clock_ms = $urandom();
      end else begin
        poll_clock_ms = poll_clock_ms + $urandom_range(0, 700);
      end

      case ($urandom_range(49))
        0:       minute = $urandom_range(1440, 2047);
        1, 2, 3, 4, 5, 6, 7, 8: begin
          minute = ($urandom_range(1) != 0) ? int'(cfg_model.light_on_minute)
                                            : int'(cfg_model.light_off_minute);
          minute = minute + int'($urandom_range(2)) - 1;
          if (minute < 0) minute = 0;
        end
        default: minute = $urandom_range(0, 1439);
      endcase

      if ($urandom_range(4) == 0) begin
        temp = pick_range(-400, 1250);
      end else begin
        temp = thr - span + int'($urandom_range(2 * span));
        if (temp < -400) temp = -400;
        if (temp > 1250) temp = 1250;
      end

      if ($urandom_range(7) == 0) dry = ~dry;
      if (dry && alarm_lvl > 0) begin
        moist = $urandom_range(0, alarm_lvl - 1);
      end else begin
        moist = $urandom_range(0, 1000);
      end

      pending_polls.push_back(make_poll(poll_clock_ms, minute, $urandom_range(9) != 0, temp,
                                        $urandom_range(9) == 0, moist,
                                        $urandom_range(9) != 0, $urandom_range(11) == 0));
    end
  endtask

  // Poll driver: a new word is offered once the previous one has been taken.
  always @(posedge clk) begin
    if (rst_n) begin
      if (poll_if.valid && poll_if.ready) begin
        expected_results.push_back(predict_result(poll_on_bus));
        polls_accepted++;
      end
      if (!poll_if.valid || poll_if.ready) begin
        if (pending_polls.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          poll_on_bus = pending_polls.pop_front();
          poll_if.now_ms              <= poll_on_bus.now_ms;
          poll_if.minute_of_day       <= poll_on_bus.minute_of_day;
          poll_if.clock_valid         <= poll_on_bus.clock_valid;
          poll_if.inside_temp         <= poll_on_bus.inside_temp;
          poll_if.inside_fault        <= poll_on_bus.inside_fault;
          poll_if.moisture_level      <= poll_on_bus.moisture_level;
          poll_if.moisture_calibrated <= poll_on_bus.moisture_calibrated;
          poll_if.moisture_fault      <= poll_on_bus.moisture_fault;
          poll_if.valid               <= 1'b1;
        end else begin
          poll_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result receiver stalls at random.
  always @(posedge clk) begin
    res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Result monitor.
  always @(posedge clk) begin
    cac_pkg::res_t exp_word;
    cac_pkg::res_t got_word;
    if (rst_n && res_if.valid && res_if.ready) begin
      got_word = {res_if.lights_on, res_if.fans_on, res_if.alarm_active, res_if.alarm_new,
                  res_if.lights_scheduled, res_if.fans_paused, res_if.schedule_enabled,
                  res_if.outputs_changed};
      if (expected_results.size() == 0) begin
        $display("%0t: result word %b arrived with no poll outstanding", $realtime, got_word);
        errors++;
      end else begin
        exp_word = expected_results.pop_front();
        for (int b = 7; b >= 0; b--) begin
          if (got_word[b] !== exp_word[b]) begin
            $display("%0t: mismatch in %s, expected %b, got %b", $realtime,
                     result_field[b], exp_word[b], got_word[b]);
            errors++;
          end
        end
        if (got_word.alarm_new) alarm_firings++;
        results_checked++;
      end
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((poll_if.valid && poll_if.ready) || (res_if.valid && res_if.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= StallLimit) begin
        $display("%0t: no word moved for %0d cycles", $realtime, stall_cycles);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = cac_pkg::CFG_ENABLE_FLAGS;
    cfg_wdata     = '0;
    poll_if.valid = 1'b0;
    poll_if.now_ms              = '0;
    poll_if.minute_of_day       = '0;
    poll_if.clock_valid         = 1'b0;
    poll_if.inside_temp         = '0;
    poll_if.inside_fault        = 1'b0;
    poll_if.moisture_level      = '0;
    poll_if.moisture_calibrated = 1'b0;
    poll_if.moisture_fault      = 1'b0;
    res_if.ready  = 1'b0;
    send_idle_pct = 28;
    recv_idle_pct = 73;
    errors          = 0;
    polls_accepted  = 0;
    results_checked = 0;
    alarm_firings   = 0;
    phase_count     = 0;
    stall_cycles    = 0;
    poll_clock_ms   = '0;

    cfg_model.enable_flags     = cac_pkg::EnableFlagsRst;
    cfg_model.light_on_minute  = cac_pkg::LightOnMinuteRst;
    cfg_model.light_off_minute = cac_pkg::LightOffMinuteRst;
    cfg_model.fan_threshold    = cac_pkg::FanThresholdRst;
    cfg_model.fan_hysteresis   = cac_pkg::FanHysteresisRst;
    cfg_model.alarm_threshold  = cac_pkg::AlarmThresholdRst;
    cfg_model.alarm_dwell_ms   = cac_pkg::AlarmDwellMsRst;
    lights_q      = 1'b0;
    fans_q        = 1'b0;
    alarm_q       = 1'b0;
    below_valid_q = 1'b0;
    below_since_q = '0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // A few polls at the reset settings: everything disabled, all holds.
    pending_polls.push_back(make_poll(32'd0, 400, 1, 1250, 0, 0, 1, 0));
    pending_polls.push_back(make_poll(32'hFFFF_FFFF, 1439, 1, -400, 1, 1000, 0, 1));
    drain();

    // Same-day window, fan hysteresis and a dwell that starts at time zero.
    write_cfg(cac_pkg::CFG_ENABLE_FLAGS, 32'd7);
    write_cfg(cac_pkg::CFG_LIGHT_ON_MINUTE, 32'd360);
    write_cfg(cac_pkg::CFG_LIGHT_OFF_MINUTE, 32'd1320);
    write_cfg(cac_pkg::CFG_FAN_THRESHOLD, 32'd280);
    write_cfg(cac_pkg::CFG_FAN_HYSTERESIS, 32'd20);
    write_cfg(cac_pkg::CFG_ALARM_THRESHOLD, 32'd300);
    write_cfg(cac_pkg::CFG_ALARM_DWELL_MS, 32'd1000);
    @(negedge clk);
    pending_polls.push_back(make_poll(32'd0, 0, 1, -400, 0, 0, 1, 0));
    pending_polls.push_back(make_poll(32'd1000, 360, 1, 280, 0, 10, 1, 0));
    pending_polls.push_back(make_poll(32'd1500, 1319, 1, 261, 0, 299, 1, 0));
    pending_polls.push_back(make_poll(32'd2000, 1320, 1, 260, 0, 299, 1, 0));
    // Inside fault holds the fans off even at the top of the range.
    pending_polls.push_back(make_poll(32'd2500, 700, 1, 1250, 1, 299, 1, 0));
    pending_polls.push_back(make_poll(32'd3000, 700, 1, 1250, 0, 299, 1, 0));
    // Clock not valid: the lights hold their state.
    pending_polls.push_back(make_poll(32'd3500, 700, 0, 1250, 0, 299, 1, 0));
    // Out-of-range minute is compared as given.
    pending_polls.push_back(make_poll(32'd4000, 2047, 1, 1250, 0, 299, 1, 0));
    // Moisture sensor faulty, then uncalibrated: the alarm clears.
    pending_polls.push_back(make_poll(32'd4500, 700, 1, 1250, 0, 100, 1, 1));
    pending_polls.push_back(make_poll(32'd5000, 700, 1, 1250, 0, 100, 0, 0));
    // Dwell across the wrap of the millisecond counter.
    pending_polls.push_back(make_poll(32'hFFFF_FF00, 700, 1, 1250, 0, 299, 1, 0));
    pending_polls.push_back(make_poll(32'h0000_02E8, 700, 1, 1250, 0, 299, 1, 0));
    drain();

    // Window wrapping past midnight, fans and alarm disabled so they hold.
    write_cfg(cac_pkg::CFG_ENABLE_FLAGS, 32'd1);
    write_cfg(cac_pkg::CFG_LIGHT_ON_MINUTE, 32'd1320);
    write_cfg(cac_pkg::CFG_LIGHT_OFF_MINUTE, 32'd360);
    @(negedge clk);
    pending_polls.push_back(make_poll(32'd6000, 1400, 1, -400, 0, 1000, 1, 0));
    pending_polls.push_back(make_poll(32'd6500, 100, 1, -400, 0, 0, 1, 0));
    pending_polls.push_back(make_poll(32'd7000, 360, 1, -400, 0, 0, 1, 0));
    pending_polls.push_back(make_poll(32'd7500, 1319, 1, -400, 0, 0, 1, 0));
    drain();

    // Equal window ends and the register extremes.
    write_cfg(cac_pkg::CFG_ENABLE_FLAGS, 32'd7);
    write_cfg(cac_pkg::CFG_LIGHT_ON_MINUTE, 32'd500);
    write_cfg(cac_pkg::CFG_LIGHT_OFF_MINUTE, 32'd500);
    write_cfg(cac_pkg::CFG_FAN_THRESHOLD, 32'(-400));
    write_cfg(cac_pkg::CFG_FAN_HYSTERESIS, 32'd1000);
    write_cfg(cac_pkg::CFG_ALARM_THRESHOLD, 32'd1000);
    write_cfg(cac_pkg::CFG_ALARM_DWELL_MS, 32'hFFFF_FFFF);
    @(negedge clk);
    pending_polls.push_back(make_poll(32'd5, 500, 1, -400, 0, 999, 1, 0));
    pending_polls.push_back(make_poll(32'd10, 0, 1, -1, 0, 999, 1, 0));
    pending_polls.push_back(make_poll(32'd20, 1439, 1, -401, 0, 1000, 1, 0));
    drain();
    write_cfg(cac_pkg::CFG_ENABLE_FLAGS, 32'd0);
    @(negedge clk);
    pending_polls.push_back(make_poll(32'd30, 700, 1, 1250, 0, 0, 1, 0));
    drain();

    // Randomized phases under the three idle patterns.
    for (int ph = 0; ph < 13; ph++) begin
      if (ph < 5) begin
        send_idle_pct = 28;
        recv_idle_pct = 73;
      end else if (ph < 9) begin
        send_idle_pct = 73;
        recv_idle_pct = 28;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      randomize_config();
      fill_random(100);
      drain();
    end

    if (expected_results.size() != 0) begin
      $display("%0t: %0d result words never arrived", $realtime, expected_results.size());
      errors++;
    end
    $display("Summary: %0d polls over %0d configuration phases, %0d result words checked,",
             polls_accepted, phase_count, results_checked);
    $display("         %0d alarm firings seen, %0d errors.", alarm_firings, errors);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
